FILE: rtl/core/bgs_pkg.sv
`timescale 1ns / 1ps

package bgs_pkg;

  localparam int unsigned INDEX_BITS_DEF = 10;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  // shared multiplier operand width (signed) and product width
  localparam int unsigned MUL_W  = 33;
  localparam int unsigned PROD_W = 2 * MUL_W;

  // sigma width and serial divider quotient bits (distance / sigma in Q16, below 16.0)
  localparam int unsigned SIG_W   = 31;
  localparam int unsigned NORM_SH = 16;
  localparam int unsigned DIV_QB  = NORM_SH + 4;
  localparam int unsigned DIV_CW  = $clog2(DIV_QB);

  // 0.1 rad per time unit as a fraction of a turn, scaled by 2^32
  localparam logic [MUL_W-1:0] OMEGA_TURN_K = 33'd68356528;
  localparam logic [30:0]      ONE_Q30      = 31'h4000_0000;
  localparam logic [MUL_W-1:0] EXP_M1_Q30   = 33'd395007542;
  localparam logic [30:0]      SIN_SEED     = 31'd172272;
  localparam logic [3:0]       EXP_TERMS    = 4'd10;
  localparam logic [9:0]       EXP_N_MAX    = 10'd24;

  // odd taylor coefficients of sine in q30, highest order first after the seed
  function automatic logic [30:0] sin_coef(input logic [1:0] idx);
    logic [30:0] c;
    case (idx)
      2'd0:    c = 31'd5026995;
      2'd1:    c = 31'd85569306;
      2'd2:    c = 31'd693598670;
      default: c = 31'd1686629713;
    endcase
    return c;
  endfunction

  // floor((2^32 - 1) / k), quotient estimate is low by at most one
  function automatic logic [31:0] exp_recip(input logic [3:0] k);
    logic [31:0] m;
    case (k)
      4'd1:    m = 32'd4294967295;
      4'd2:    m = 32'd2147483647;
      4'd3:    m = 32'd1431655765;
      4'd4:    m = 32'd1073741823;
      4'd5:    m = 32'd858993459;
      4'd6:    m = 32'd715827882;
      4'd7:    m = 32'd613566756;
      4'd8:    m = 32'd536870911;
      4'd9:    m = 32'd477218588;
      4'd10:   m = 32'd429496729;
      default: m = 32'd0;
    endcase
    return m;
  endfunction

endpackage

FILE: rtl/core/bgs_mul.sv
`timescale 1ns / 1ps

module bgs_mul import bgs_pkg::*; (
  input  logic                     clk_i,
  input  logic signed [MUL_W-1:0]  a_i,
  input  logic signed [MUL_W-1:0]  b_i,
  output logic signed [PROD_W-1:0] p_o
);

  logic signed [PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

FILE: rtl/core/bgs_div.sv
`timescale 1ns / 1ps

module bgs_div import bgs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SIG_W-1:0]  num_hi_i,
  input  logic [3:0]        num_lo_i,
  input  logic [SIG_W-1:0]  den_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [DIV_QB-1:0] quot_o
);

  logic              busy_q, done_q;
  logic [DIV_CW-1:0] cnt_q;
  logic [SIG_W-1:0]  rem_q, den_q;
  logic [DIV_QB-1:0] sh_q, quot_q;
  logic [SIG_W:0]    trial;
  logic              ge;

  // restoring step, one quotient bit a cycle
  assign trial = {rem_q, sh_q[DIV_QB-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CW'(DIV_QB - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_hi_i;
      den_q  <= den_i;
      sh_q   <= {num_lo_i, NORM_SH'(0)};
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? SIG_W'(trial - {1'b0, den_q}) : trial[SIG_W-1:0];
      sh_q   <= {sh_q[DIV_QB-2:0], 1'b0};
      quot_q <= {quot_q[DIV_QB-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quot_q;

  ap_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider restarted while busy");

  ap_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("divider done held");

endmodule

FILE: rtl/core/binary_gaussian_source_grid.sv
`timescale 1ns / 1ps
// channel | direction | handshake                | payload
// in      | input     | in_valid_i / in_ready_o   | op, time_step, index_*, origin_*, step_*
// out     | output    | out_valid_o / out_ready_i | source_value
// cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// one item at a time through a sequencer around one 33x33 multiplier and a
// bit-serial divider; the multiplier and the divider set the pace
// a grid point is dominated by up to six serial divisions and up to 23 e^-1
// multiplies per source
// after reset the offsets are computed before any beat is taken
// a finished result waits in the output register; the next item is taken meanwhile

module binary_gaussian_source_grid import bgs_pkg::*; #(
  parameter int unsigned INDEX_BITS = INDEX_BITS_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  op_i,
  input  logic [31:0]           time_step_i,
  input  logic [INDEX_BITS-1:0] index_i_i,
  input  logic [INDEX_BITS-1:0] index_j_i,
  input  logic [INDEX_BITS-1:0] index_k_i,
  input  logic [31:0]           origin_x_i,
  input  logic [31:0]           origin_y_i,
  input  logic [31:0]           origin_z_i,
  input  logic [30:0]           step_x_i,
  input  logic [30:0]           step_y_i,
  input  logic [30:0]           step_z_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [31:0]           source_value_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [2:0]            cfg_index_i,
  input  logic [31:0]           cfg_data_i
);

  localparam int unsigned CW = INDEX_BITS + 33; // grid coordinate width
  localparam int unsigned DW = CW + 1;          // distance width

  typedef enum logic [2:0] {
    REG_CENTER_X  = 3'd0,
    REG_CENTER_Y  = 3'd1,
    REG_CENTER_Z  = 3'd2,
    REG_SEP       = 3'd3,
    REG_WIDTH     = 3'd4,
    REG_AMP       = 3'd5,
    REG_INIT_PH   = 3'd6
  } reg_idx_e;

  typedef enum logic [23:0] {
    S_IDLE    = 24'h000001,
    S_PH_MUL  = 24'h000002,
    S_PH_WB   = 24'h000004,
    S_TR_SQ   = 24'h000008,
    S_TR_SQW  = 24'h000010,
    S_TR_H    = 24'h000020,
    S_TR_HW   = 24'h000040,
    S_TR_F    = 24'h000080,
    S_TR_FW   = 24'h000100,
    S_TR_O    = 24'h000200,
    S_TR_OW   = 24'h000400,
    S_GR_MUL  = 24'h000800,
    S_GR_WB   = 24'h001000,
    S_DS_SET  = 24'h002000,
    S_DS_DIV  = 24'h004000,
    S_DS_SQ   = 24'h008000,
    S_DS_SQW  = 24'h010000,
    S_EX_MUL  = 24'h020000,
    S_EX_MWB  = 24'h040000,
    S_EX_RWB  = 24'h080000,
    S_EN_MUL  = 24'h100000,
    S_EN_WB   = 24'h200000,
    S_FIN_MUL = 24'h400000,
    S_FIN_WB  = 24'h800000
  } state_e;

  state_e st_q, st_d;

  // configuration
  logic [31:0] cx_q, cy_q, cz_q, amp_q, init_ph_q;
  logic [30:0] sep_q, wid_q;

  // orbit state
  logic [31:0] phase_q, phase_d, offx_q, offx_d, offy_q, offy_d;

  // latched item
  logic                  ts_op_q;
  logic [31:0]           ts_q;
  logic [INDEX_BITS-1:0] idx_q [3];
  logic [31:0]           org_q [3];
  logic [30:0]           stp_q [3];

  // sequencer counters
  logic       tp_q, tp_d;
  logic [1:0] hc_q, hc_d, ax_q, ax_d;
  logic       src_q, src_d;
  logic [3:0] k_q, k_d;
  logic [4:0] ncnt_q, ncnt_d;

  // datapath registers
  logic [1:0]         quad_q, quad_d;
  logic [30:0]        tq_q, tq_d, t2_q, t2_d, r_q, r_d, xq_q, xq_d;
  logic signed [31:0] trig_q, trig_d;
  logic signed [CW-1:0] gc_q [3];
  logic signed [CW-1:0] gc_d [3];
  logic [20:0]        v_q, v_d;
  logic [42:0]        acc_q, acc_d;
  logic [29:0]        te_q, te_d;
  logic [31:0]        gsum_q, gsum_d;
  logic               out_valid_q, out_valid_d;
  logic [31:0]        res_q, res_d;

  // shared units
  logic signed [MUL_W-1:0]  ma, mb;
  logic signed [PROD_W-1:0] mp;
  logic                     div_start, div_busy, div_done;
  logic [DIV_QB-1:0]        div_q;

  // combinational helpers
  logic [31:0]          pp;
  logic [30:0]          t_c, r2, q0, q_fix, rem_c;
  logic [34:0]          q0k;
  logic [30:0]          sig;
  logic signed [32:0]   ref_c, off_c;
  logic signed [DW-1:0] d_c;
  logic [DW-1:0]        a_c;
  logic                 sat_c;
  logic [42:0]          acc_n;
  logic                 in_acc, cfg_acc;

  assign sig     = (wid_q == '0) ? 31'd1 : wid_q;
  assign in_acc  = in_valid_i && in_ready_o;
  assign cfg_acc = cfg_valid_i && cfg_ready_o;

  bgs_mul u_mul (
    .clk_i (clk_i),
    .a_i   (ma),
    .b_i   (mb),
    .p_o   (mp)
  );

  bgs_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_hi_i (a_c[4 +: SIG_W]),
    .num_lo_i (a_c[3:0]),
    .den_i    (sig),
    .busy_o   (div_busy),
    .done_o   (div_done),
    .quot_o   (div_q)
  );

  // sine argument: quarter-wave folding, cosine is a quarter turn ahead
  always_comb begin
    pp  = tp_q ? phase_q : phase_q + 32'h4000_0000;
    t_c = pp[30] ? ONE_Q30 - {1'b0, pp[29:0]} : {1'b0, pp[29:0]};
  end

  // distance from the grid point to the current source on the current axis
  always_comb begin
    off_c = 33'sd0;
    ref_c = {cz_q[31], cz_q};
    case (ax_q)
      2'd0: begin
        off_c = {offx_q[31], offx_q};
        ref_c = {cx_q[31], cx_q};
      end
      2'd1: begin
        off_c = {offy_q[31], offy_q};
        ref_c = {cy_q[31], cy_q};
      end
      default: ;
    endcase
    ref_c = src_q ? ref_c - off_c : ref_c + off_c;
    d_c   = {gc_q[ax_q][CW-1], gc_q[ax_q]} - {{(DW-33){ref_c[32]}}, ref_c};
    a_c   = d_c[DW-1] ? DW'(-d_c) : DW'(d_c);
    sat_c = a_c >= {{(DW-SIG_W-4){1'b0}}, sig, 4'b0};
  end

  // divide by k: reciprocal estimate then one correction
  always_comb begin
    q0    = mp[62:32];
    q0k   = q0 * k_q;
    rem_c = xq_q - q0k[30:0];
    q_fix = (rem_c >= {27'b0, k_q}) ? q0 + 31'd1 : q0;
    r2    = (mp[60:30] > ONE_Q30) ? ONE_Q30 : mp[60:30];
    acc_n = acc_q + mp[42:0];
  end

  // multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (st_q) inside
      S_PH_MUL: begin
        ma = {ts_q[31], ts_q};
        mb = OMEGA_TURN_K;
      end
      S_TR_SQ: begin
        ma = {2'b0, t_c};
        mb = {2'b0, t_c};
      end
      S_TR_H: begin
        ma = {2'b0, t2_q};
        mb = {2'b0, r_q};
      end
      S_TR_F: begin
        ma = {2'b0, tq_q};
        mb = {2'b0, r_q};
      end
      S_TR_O: begin
        ma = {2'b0, sep_q};
        mb = {trig_q[31], trig_q};
      end
      S_GR_MUL: begin
        ma = MUL_W'(idx_q[ax_q]);
        mb = {2'b0, stp_q[ax_q]};
      end
      S_DS_SQ: begin
        ma = MUL_W'(v_q);
        mb = MUL_W'(v_q);
      end
      S_EX_MUL: begin
        ma = {3'b0, te_q};
        mb = {2'b0, r_q};
      end
      S_EX_MWB: begin
        ma = {2'b0, mp[60:30]};
        mb = {1'b0, exp_recip(k_q)};
      end
      S_EN_MUL: begin
        ma = {2'b0, r_q};
        mb = EXP_M1_Q30;
      end
      S_FIN_MUL, S_FIN_WB: begin
        // held while a previous result still waits
        ma = {amp_q[31], amp_q};
        mb = {1'b0, gsum_q};
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    st_d        = st_q;
    phase_d     = phase_q;
    offx_d      = offx_q;
    offy_d      = offy_q;
    tp_d        = tp_q;
    hc_d        = hc_q;
    ax_d        = ax_q;
    src_d       = src_q;
    k_d         = k_q;
    ncnt_d      = ncnt_q;
    quad_d      = quad_q;
    tq_d        = tq_q;
    t2_d        = t2_q;
    r_d         = r_q;
    xq_d        = xq_q;
    trig_d      = trig_q;
    gc_d        = gc_q;
    v_d         = v_q;
    acc_d       = acc_q;
    te_d        = te_q;
    gsum_d      = gsum_q;
    res_d       = res_q;
    div_start   = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (st_q)
      S_IDLE: begin
        if (cfg_acc && reg_idx_e'(cfg_index_i) == REG_INIT_PH) begin
          phase_d = cfg_data_i;
          tp_d    = 1'b0;
          st_d    = S_TR_SQ;
        end else if (in_acc) begin
          ax_d = 2'd0;
          st_d = op_i ? S_GR_MUL : S_PH_MUL;
        end
      end
      S_PH_MUL: st_d = S_PH_WB;
      S_PH_WB: begin
        phase_d = phase_q + mp[FRAC_BITS +: 32];
        tp_d    = 1'b0;
        st_d    = S_TR_SQ;
      end
      S_TR_SQ: begin
        quad_d = pp[31:30];
        tq_d   = t_c;
        st_d   = S_TR_SQW;
      end
      S_TR_SQW: begin
        t2_d = mp[60:30];
        r_d  = SIN_SEED;
        hc_d = 2'd0;
        st_d = S_TR_H;
      end
      S_TR_H: st_d = S_TR_HW;
      S_TR_HW: begin
        r_d  = sin_coef(hc_q) - mp[60:30];
        hc_d = hc_q + 2'd1;
        st_d = (hc_q == 2'd3) ? S_TR_F : S_TR_H;
      end
      S_TR_F: st_d = S_TR_FW;
      S_TR_FW: begin
        trig_d = quad_q[1] ? -$signed({1'b0, r2}) : $signed({1'b0, r2});
        st_d   = S_TR_O;
      end
      S_TR_O: st_d = S_TR_OW;
      S_TR_OW: begin
        if (tp_q) begin
          offy_d = mp[62:31];
          st_d   = S_IDLE;
        end else begin
          offx_d = mp[62:31];
          tp_d   = 1'b1;
          st_d   = S_TR_SQ;
        end
      end
      S_GR_MUL: st_d = S_GR_WB;
      S_GR_WB: begin
        gc_d[ax_q] = $signed({{(CW-32){org_q[ax_q][31]}}, org_q[ax_q]})
                   + $signed({2'b0, mp[INDEX_BITS+30:0]});
        if (ax_q == 2'd2) begin
          ax_d   = 2'd0;
          src_d  = 1'b0;
          acc_d  = '0;
          gsum_d = '0;
          st_d   = S_DS_SET;
        end else begin
          ax_d = ax_q + 2'd1;
          st_d = S_GR_MUL;
        end
      end
      S_DS_SET: begin
        if (sat_c) begin
          v_d  = 21'h10_0000;
          st_d = S_DS_SQ;
        end else begin
          div_start = 1'b1;
          st_d      = S_DS_DIV;
        end
      end
      S_DS_DIV: begin
        if (div_done) begin
          v_d  = {1'b0, div_q};
          st_d = S_DS_SQ;
        end
      end
      S_DS_SQ: st_d = S_DS_SQW;
      S_DS_SQW: begin
        acc_d = acc_n;
        if (ax_q == 2'd2) begin
          ax_d = 2'd0;
          if (acc_n[42:33] >= EXP_N_MAX) begin
            r_d    = '0;
            ncnt_d = '0;
            st_d   = S_EN_MUL;
          end else begin
            te_d   = acc_n[32:3];
            ncnt_d = acc_n[37:33];
            r_d    = ONE_Q30;
            k_d    = EXP_TERMS;
            st_d   = S_EX_MUL;
          end
        end else begin
          ax_d = ax_q + 2'd1;
          st_d = S_DS_SET;
        end
      end
      S_EX_MUL: st_d = S_EX_MWB;
      S_EX_MWB: begin
        xq_d = mp[60:30];
        st_d = S_EX_RWB;
      end
      S_EX_RWB: begin
        r_d = ONE_Q30 - q_fix;
        k_d = k_q - 4'd1;
        st_d = (k_q == 4'd1) ? S_EN_MUL : S_EX_MUL;
      end
      S_EN_MUL: begin
        if (ncnt_q == '0) begin
          gsum_d = gsum_q + {1'b0, r_q};
          if (src_q) begin
            st_d = S_FIN_MUL;
          end else begin
            src_d = 1'b1;
            acc_d = '0;
            st_d  = S_DS_SET;
          end
        end else begin
          st_d = S_EN_WB;
        end
      end
      S_EN_WB: begin
        r_d    = mp[60:30];
        ncnt_d = ncnt_q - 5'd1;
        st_d   = S_EN_MUL;
      end
      S_FIN_MUL: st_d = S_FIN_WB;
      S_FIN_WB: begin
        if (!out_valid_q || out_ready_i) begin
          // saturate floor(amp * sum / 2^30) to 32 bits
          if (mp[65:61] == {5{mp[61]}}) begin
            res_d = mp[61:30];
          end else begin
            res_d = mp[65] ? 32'h8000_0000 : 32'h7FFF_FFFF;
          end
          out_valid_d = 1'b1;
          st_d        = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  // control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_TR_SQ;
      tp_q        <= 1'b0;
      hc_q        <= '0;
      ax_q        <= '0;
      src_q       <= 1'b0;
      k_q         <= '0;
      ncnt_q      <= '0;
      out_valid_q <= 1'b0;
      phase_q     <= '0;
      cx_q        <= '0;
      cy_q        <= '0;
      cz_q        <= '0;
      sep_q       <= 31'(64'd1 << FRAC_BITS);
      wid_q       <= 31'(64'd1 << FRAC_BITS);
      amp_q       <= 32'(64'd1 << FRAC_BITS);
      init_ph_q   <= '0;
    end else begin
      st_q        <= st_d;
      tp_q        <= tp_d;
      hc_q        <= hc_d;
      ax_q        <= ax_d;
      src_q       <= src_d;
      k_q         <= k_d;
      ncnt_q      <= ncnt_d;
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
      if (cfg_acc) begin
        unique case (reg_idx_e'(cfg_index_i))
          REG_CENTER_X: cx_q      <= cfg_data_i;
          REG_CENTER_Y: cy_q      <= cfg_data_i;
          REG_CENTER_Z: cz_q      <= cfg_data_i;
          REG_SEP:      sep_q     <= cfg_data_i[30:0];
          REG_WIDTH:    wid_q     <= cfg_data_i[30:0];
          REG_AMP:      amp_q     <= cfg_data_i;
          REG_INIT_PH:  init_ph_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    offx_q <= offx_d;
    offy_q <= offy_d;
    quad_q <= quad_d;
    tq_q   <= tq_d;
    t2_q   <= t2_d;
    r_q    <= r_d;
    xq_q   <= xq_d;
    trig_q <= trig_d;
    gc_q   <= gc_d;
    v_q    <= v_d;
    acc_q  <= acc_d;
    te_q   <= te_d;
    gsum_q <= gsum_d;
    res_q  <= res_d;
    if (in_acc) begin
      ts_op_q  <= op_i;
      ts_q     <= time_step_i;
      idx_q[0] <= index_i_i;
      idx_q[1] <= index_j_i;
      idx_q[2] <= index_k_i;
      org_q[0] <= origin_x_i;
      org_q[1] <= origin_y_i;
      org_q[2] <= origin_z_i;
      stp_q[0] <= step_x_i;
      stp_q[1] <= step_y_i;
      stp_q[2] <= step_z_i;
    end
  end

  // only the idle state takes beats; a config beat wins over an item beat
  assign in_ready_o     = (st_q == S_IDLE) && !cfg_valid_i;
  assign cfg_ready_o    = (st_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign source_value_o = res_q;

  ap_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(st_q) == S_FIN_WB)
    else $error("result raised outside the final step");

  ap_div_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_DS_DIV |-> div_busy || div_done)
    else $error("waiting on an idle divider");

  ap_exp_quot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_EX_RWB |-> q_fix <= ONE_Q30)
    else $error("exp quotient above one");

  ap_trig_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_TR_O |-> (trig_q <= 32'sh4000_0000 && trig_q >= -32'sh4000_0000))
    else $error("trig value out of range");

  ap_item_op_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_PH_MUL |-> !ts_op_q)
    else $error("orbit advance on a grid item");

endmodule
